// File: rtl/lph_pkg.sv
package lph_pkg;

  // Request operation codes
  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  // Slot status codes
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  // Probe outcome codes
  localparam logic [1:0] PR_MATCH = 2'd0;
  localparam logic [1:0] PR_EMPTY = 2'd1;
  localparam logic [1:0] PR_TOMB  = 2'd2;
  localparam logic [1:0] PR_NONE  = 2'd3;

  localparam logic [8:0] MAX_FILL_RESET = 9'd192;
  localparam int         HASH_W         = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic load_req;
    logic idx_from_hash;
    logic mod_start;
    logic mod_step;
    logic advance;
    logic rec_tomb;
    logic use_tomb;
    logic wr_used;
    logic wr_tomb;
    logic wr_key;
    logic wr_val;
    logic fill_inc;
    logic out_load;
    logic out_found;
    logic out_val_sel;
    logic out_new_key;
    logic out_full;
  } lph_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       st_empty;
    logic       st_used;
    logic       key_match;
    logic       have_tomb;
    logic       probe_last;
    logic       mod_last;
    logic       clr_last;
    logic       fill_ok;
    logic       fill_nz;
    logic       out_busy;
  } lph_stat_t;

endpackage

// File: rtl/linear_probe_hash_table_top.sv
// Key/value table of SLOTS entries with linear probing and tombstones. Each
// input beat is a get, set or delete; each produces exactly one result beat.
// After reset the block sweeps the slot status memory to empty and holds
// in_ready low meanwhile; configuration writes are taken at any time. A
// request goes from acceptance through states that hash the key, issue the
// first memory read, examine the probed slots in turn (the slot memories give
// one registered read a cycle) and commit the update, then back to idle to
// take the next beat. When SLOTS is not a power of two the hash is reduced by
// a reciprocal-multiply remainder unit before the first read. Deletes on an
// empty table and undefined operation codes skip the probe and go from the
// hash state straight to the commit. The result register lets the next
// request be accepted while a result waits; a result still not taken when the
// next one is ready holds the commit cycle until the receiver takes it.
module linear_probe_hash_table_top
  import lph_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_max_fill,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_key_bits,
  input  logic        in_key_is_string,
  input  logic [31:0] in_string_hash,
  input  logic [63:0] in_store_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_value_out,
  output logic        out_new_key,
  output logic        out_table_full
);

  lph_cmd_t  cmd;
  lph_stat_t stat;

  assign cfg_ready = 1'b1;

  lph_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  lph_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_operation),
    .in_key_bits     (in_key_bits),
    .in_key_is_string(in_key_is_string),
    .in_string_hash  (in_string_hash),
    .in_store_value  (in_store_value),
    .cfg_valid       (cfg_valid),
    .cfg_max_fill    (cfg_max_fill),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_value_out   (out_value_out),
    .out_new_key     (out_new_key),
    .out_table_full  (out_table_full)
  );

endmodule

// File: rtl/lph_datapath.sv
module lph_datapath
  import lph_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lph_cmd_t    cmd,
  output lph_stat_t   stat,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_key_bits,
  input  logic        in_key_is_string,
  input  logic [31:0] in_string_hash,
  input  logic [63:0] in_store_value,
  input  logic        cfg_valid,
  input  logic [8:0]  cfg_max_fill,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_value_out,
  output logic        out_new_key,
  output logic        out_table_full
);

  localparam int IDX_W = $clog2(SLOTS);
  // floor(2^32 / SLOTS): the estimated quotient is low by at most one
  localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / 64'(SLOTS));

  // Request registers
  logic [1:0]  op_r;
  logic [63:0] key_r;
  logic        kind_r;
  logic [31:0] shash_r;
  logic [63:0] sval_r;

  // Probe registers
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] n_r;
  logic [IDX_W-1:0] tomb_r;
  logic             have_tomb_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  // Modulo unit
  logic [HASH_W-1:0]   hsh_r;
  logic [2*HASH_W-1:0] prod_r;
  logic [HASH_W-1:0]   rest_r;
  logic [HASH_W-1:0]   rest_fix;
  logic [1:0]          cnt_r;

  // Fill tracking
  logic [8:0] fill_r;
  logic [8:0] max_fill_r;

  // Memories
  logic [1:0]  st_mem  [SLOTS];
  logic [64:0] key_mem [SLOTS];
  logic [63:0] val_mem [SLOTS];
  logic [1:0]  st_rd_r;
  logic [64:0] key_rd_r;
  logic [63:0] val_rd_r;
  logic        st_we;
  logic [1:0]  st_wdata;

  // Output register
  logic        out_valid_r;
  logic        out_found_r;
  logic [63:0] out_value_r;
  logic        out_new_key_r;
  logic        out_full_r;

  // Number hash
  logic [31:0] folded;
  logic [10:0] expo;
  logic [63:0] mant;
  logic [5:0]  ex6;
  logic [5:0]  rsh;
  logic [5:0]  lsh;
  logic        lost;
  logic [63:0] mag;
  logic [31:0] num_hash;
  logic [31:0] hash_val;

  always_comb begin
    folded   = key_r[31:0] ^ key_r[63:32];
    expo     = key_r[62:52];
    mant     = {11'd0, 1'b1, key_r[51:0]};
    ex6      = 6'(expo - 11'd1023);
    rsh      = 6'd52 - ex6;
    lsh      = ex6 - 6'd52;
    lost     = 1'b0;
    mag      = 64'd0;
    num_hash = folded;
    if (expo == 11'd0) begin
      num_hash = (key_r[51:0] == 52'd0) ? 32'd0 : folded;
    end else if (key_r == 64'hC3E0_0000_0000_0000) begin
      num_hash = 32'd0;
    end else if (expo < 11'd1023 || expo >= 11'd1086) begin
      num_hash = folded;
    end else begin
      if (ex6 < 6'd52) begin
        lost = (mant & ~(64'hFFFF_FFFF_FFFF_FFFF << rsh)) != 64'd0;
        mag  = mant >> rsh;
      end else begin
        mag = mant << lsh;
      end
      if (lost) begin
        num_hash = folded;
      end else if (key_r[63]) begin
        num_hash = 32'd0 - mag[31:0];
      end else begin
        num_hash = mag[31:0];
      end
    end
    hash_val = kind_r ? shash_r : num_hash;
  end

  // Wrap the probe index and fix up the estimated remainder
  always_comb begin
    idx_inc  = (idx_r == IDX_W'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
    rest_fix = (rest_r >= HASH_W'(SLOTS)) ? rest_r - HASH_W'(SLOTS) : rest_r;
  end

  // Latch request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r    <= in_operation;
      key_r   <= in_key_bits;
      kind_r  <= in_key_is_string;
      shash_r <= in_string_hash;
      sval_r  <= in_store_value;
    end
  end

  // Probe index, step count and first tombstone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      n_r         <= '0;
      have_tomb_r <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        have_tomb_r <= 1'b0;
      end
      if (cmd.idx_from_hash) begin
        idx_r <= hash_val[IDX_W-1:0];
        n_r   <= '0;
      end
      if (cmd.mod_step && cnt_r == 2'd2) begin
        idx_r <= rest_fix[IDX_W-1:0];
        n_r   <= '0;
      end
      if (cmd.advance) begin
        idx_r <= idx_inc;
        n_r   <= n_r + 1'b1;
      end
      if (cmd.rec_tomb) begin
        have_tomb_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_tomb) begin
      tomb_r <= idx_r;
    end
  end

  // Reduce the hash modulo the slot count: multiply by the reciprocal,
  // subtract the quotient times SLOTS, then correct once
  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      hsh_r <= hash_val;
      cnt_r <= 2'd0;
    end else if (cmd.mod_step) begin
      prod_r <= (2*HASH_W)'(hsh_r) * (2*HASH_W)'(RECIP);
      rest_r <= hsh_r - HASH_W'(prod_r[2*HASH_W-1:HASH_W] * HASH_W'(SLOTS));
      cnt_r  <= cnt_r + 2'd1;
    end
  end

  // Fill count and limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 9'd0;
      max_fill_r <= MAX_FILL_RESET;
    end else begin
      if (cmd.fill_inc) begin
        fill_r <= fill_r + 9'd1;
      end
      if (cfg_valid) begin
        max_fill_r <= cfg_max_fill;
      end
    end
  end

  // Memory addressing
  always_comb begin
    rd_addr  = cmd.advance ? idx_inc : idx_r;
    wr_addr  = cmd.use_tomb ? tomb_r : idx_r;
    st_we    = cmd.clr_wr | cmd.wr_used | cmd.wr_tomb;
    st_wdata = cmd.clr_wr ? ST_EMPTY : (cmd.wr_used ? ST_USED : ST_TOMB);
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[wr_addr] <= st_wdata;
    end
    st_rd_r <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_key) begin
      key_mem[wr_addr] <= {kind_r, key_r};
    end
    key_rd_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_val) begin
      val_mem[wr_addr] <= sval_r;
    end
    val_rd_r <= val_mem[rd_addr];
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r   <= cmd.out_found;
      out_value_r   <= cmd.out_val_sel ? val_rd_r : 64'd0;
      out_new_key_r <= cmd.out_new_key;
      out_full_r    <= cmd.out_full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_value_out  = out_value_r;
  assign out_new_key    = out_new_key_r;
  assign out_table_full = out_full_r;

  // Status to controller
  always_comb begin
    stat.op         = op_r;
    stat.st_empty   = st_rd_r == ST_EMPTY;
    stat.st_used    = st_rd_r == ST_USED;
    stat.key_match  = key_rd_r == {kind_r, key_r};
    stat.have_tomb  = have_tomb_r;
    stat.probe_last = n_r == IDX_W'(SLOTS - 1);
    stat.mod_last   = cnt_r == 2'd2;
    stat.clr_last   = idx_r == IDX_W'(SLOTS - 1);
    stat.fill_ok    = ({1'b0, fill_r} + 10'd1) <= {1'b0, max_fill_r};
    stat.fill_nz    = fill_r != 9'd0;
    stat.out_busy   = out_valid_r & ~out_ready;
  end

endmodule

// File: rtl/lph_ctrl.sv
module lph_ctrl
  import lph_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lph_stat_t stat,
  output lph_cmd_t  cmd
);

  localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_ACT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] res_r;
  logic [1:0] res_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    unique case (state_r)
      // Sweep every slot to empty after reset
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.advance = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_HASH;
        end
      end
      // Skip the probe for undefined codes and deletes on an empty table
      S_HASH: begin
        if (stat.op != OP_GET && stat.op != OP_SET &&
            (stat.op != OP_DEL || !stat.fill_nz)) begin
          res_nxt   = PR_NONE;
          state_nxt = S_ACT;
        end else if (IS_POW2) begin
          cmd.idx_from_hash = 1'b1;
          state_nxt         = S_READ;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      // Examine one slot a cycle
      S_CHECK: begin
        if (stat.st_empty) begin
          res_nxt   = stat.have_tomb ? PR_TOMB : PR_EMPTY;
          state_nxt = S_ACT;
        end else if (stat.st_used && stat.key_match) begin
          res_nxt   = PR_MATCH;
          state_nxt = S_ACT;
        end else begin
          if (!stat.st_used && !stat.have_tomb) begin
            cmd.rec_tomb = 1'b1;
          end
          if (stat.probe_last) begin
            res_nxt   = (stat.have_tomb || !stat.st_used) ? PR_TOMB : PR_NONE;
            state_nxt = S_ACT;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      // Commit the update and load the result beat
      S_ACT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
          case (stat.op)
            OP_GET: begin
              cmd.out_found   = res_r == PR_MATCH;
              cmd.out_val_sel = res_r == PR_MATCH;
            end
            OP_SET: begin
              if (res_r == PR_MATCH) begin
                cmd.wr_val = 1'b1;
              end else if (res_r == PR_NONE ||
                           (res_r == PR_EMPTY && !stat.fill_ok)) begin
                cmd.out_full = 1'b1;
              end else begin
                cmd.use_tomb    = res_r == PR_TOMB;
                cmd.fill_inc    = res_r == PR_EMPTY;
                cmd.wr_used     = 1'b1;
                cmd.wr_key      = 1'b1;
                cmd.wr_val      = 1'b1;
                cmd.out_new_key = 1'b1;
              end
            end
            OP_DEL: begin
              if (res_r == PR_MATCH) begin
                cmd.wr_tomb   = 1'b1;
                cmd.out_found = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      res_r   <= PR_NONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

// File: test/lph_table_checker.sv
`timescale 1ns / 100ps

// Watch the request, result and register channels, keep a shadow copy of the
// table and compare every result beat with the answer predicted for it.
module lph_table_checker
  import lph_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [8:0]  cfg_max_fill,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_key_bits,
  input  logic        in_key_is_string,
  input  logic [31:0] in_string_hash,
  input  logic [63:0] in_store_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_found,
  input  logic [63:0] out_value_out,
  input  logic        out_new_key,
  input  logic        out_table_full,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        found;
    logic [63:0] value;
    logic        new_key;
    logic        full;
  } answer_t;

  localparam logic [63:0] NEG_TWO_POW_63 = 64'hC3E0_0000_0000_0000;

  // Shadow of the slot memories and fill bookkeeping
  logic [63:0] slot_key   [SLOTS];
  logic        slot_kind  [SLOTS];
  logic [63:0] slot_val   [SLOTS];
  logic [1:0]  slot_state [SLOTS];
  int          used_count;
  logic [8:0]  fill_limit;
  answer_t     pending_answers [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Integral doubles of magnitude below 2^63 hash to the low word of their
  // integer, others to the xor of halves; zero of either sign and -2^63 to zero.
  function automatic logic [31:0] number_hash(input logic [63:0] b);
    logic [31:0] folded;
    logic [10:0] expo;
    logic [63:0] frac;
    logic [63:0] mag;
    int          ex;
    int          sh;
    folded = b[31:0] ^ b[63:32];
    expo   = b[62:52];
    frac   = {12'd0, b[51:0]};
    if (expo == 11'd0) return (frac == 64'd0) ? 32'd0 : folded;
    if (b == NEG_TWO_POW_63) return 32'd0;
    if (expo < 11'd1023 || expo >= 11'd1086) return folded;
    ex = int'(expo) - 1023;
    frac[52] = 1'b1;
    if (ex < 52) begin
      sh = 52 - ex;
      if ((frac & ((64'd1 << sh) - 64'd1)) != 64'd0) return folded;
      mag = frac >> sh;
    end else begin
      mag = frac << (ex - 52);
    end
    if (b[63]) mag = -mag;
    return mag[31:0];
  endfunction

  // Walk forward from the home slot; remember the first tombstone on the way
  function automatic logic [1:0] find_slot(input logic [63:0] key, input logic kind,
                                           input logic [31:0] h, output int where);
    int idx;
    int tomb;
    bit have_tomb;
    idx       = int'(h % SLOTS);
    tomb      = 0;
    have_tomb = 1'b0;
    where     = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_state[idx] == ST_EMPTY) begin
        where = have_tomb ? tomb : idx;
        return have_tomb ? PR_TOMB : PR_EMPTY;
      end
      if (slot_state[idx] == ST_USED) begin
        if (slot_kind[idx] == kind && slot_key[idx] == key) begin
          where = idx;
          return PR_MATCH;
        end
      end else if (!have_tomb) begin
        have_tomb = 1'b1;
        tomb      = idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    where = tomb;
    return have_tomb ? PR_TOMB : PR_NONE;
  endfunction

  // Apply one request to the shadow table and return its answer
  function automatic answer_t predict_answer(input logic [1:0] op, input logic [63:0] key,
                                             input logic kind, input logic [31:0] shash,
                                             input logic [63:0] val);
    answer_t    a;
    logic [31:0] h;
    logic [1:0] outcome;
    int         w;
    a = '0;
    h = kind ? shash : number_hash(key);
    case (op)
      OP_GET: begin
        outcome = find_slot(key, kind, h, w);
        if (outcome == PR_MATCH) begin
          a.found = 1'b1;
          a.value = slot_val[w];
        end
      end
      OP_SET: begin
        outcome = find_slot(key, kind, h, w);
        if (outcome == PR_MATCH) begin
          slot_val[w] = val;
        end else if (outcome == PR_NONE ||
                     (outcome == PR_EMPTY && used_count + 1 > int'(fill_limit))) begin
          a.full = 1'b1;
        end else begin
          // a reused tombstone keeps the fill count
          if (outcome == PR_EMPTY) used_count++;
          slot_state[w] = ST_USED;
          slot_kind[w]  = kind;
          slot_key[w]   = key;
          slot_val[w]   = val;
          a.new_key     = 1'b1;
        end
      end
      OP_DEL: begin
        if (used_count != 0) begin
          outcome = find_slot(key, kind, h, w);
          if (outcome == PR_MATCH) begin
            slot_state[w] = ST_TOMB;
            a.found       = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_state[i] = ST_EMPTY;
      used_count = 0;
      fill_limit = MAX_FILL_RESET;
      pending_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) fill_limit = cfg_max_fill;
      // Check the result beat against the oldest answer
      if (out_valid && out_ready) begin
        got = '{out_found, out_value_out, out_new_key, out_table_full};
        if (pending_answers.size() == 0) begin
          report("result beat with no request outstanding", 64'd0, 64'd0);
        end else begin
          want = pending_answers.pop_front();
          if (got.found !== want.found) report("found", got.found, want.found);
          if (got.value !== want.value) report("value_out", got.value, want.value);
          if (got.new_key !== want.new_key) report("new_key", got.new_key, want.new_key);
          if (got.full !== want.full) report("table_full", got.full, want.full);
        end
      end
      // Predict the answer of each accepted request beat
      if (in_valid && in_ready)
        pending_answers.push_back(predict_answer(in_operation, in_key_bits, in_key_is_string,
                                                 in_string_hash, in_store_value));
    end
    pending <= pending_answers.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lph_pkg::*;

  localparam int         TABLE_SLOTS = 256;
  localparam int         POOL        = 64;
  localparam int         IDLE_PCT    = 31;
  localparam int         HOLD_CYCLES = 400;
  localparam logic [1:0] OP_UNDEF    = 2'd3;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_max_fill = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_GET;
  logic [63:0] in_key_bits = '0;
  logic        in_key_is_string = 1'b0;
  logic [31:0] in_string_hash = '0;
  logic [63:0] in_store_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [63:0] out_value_out;
  logic        out_new_key;
  logic        out_table_full;

  int          mismatches;
  int          pending;
  logic        burst = 1'b0;
  logic        start_hold = 1'b0;
  logic        hold_rx = 1'b0;

  // Reused keys so that requests hit, collide and walk over tombstones
  logic [63:0] pool_key  [POOL];
  logic        pool_kind [POOL];
  logic [31:0] pool_hash [POOL];

  linear_probe_hash_table_top #(.SLOTS(TABLE_SLOTS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_fill    (cfg_max_fill),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key_bits     (in_key_bits),
    .in_key_is_string(in_key_is_string),
    .in_string_hash  (in_string_hash),
    .in_store_value  (in_store_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_value_out   (out_value_out),
    .out_new_key     (out_new_key),
    .out_table_full  (out_table_full)
  );

  lph_table_checker #(.SLOTS(TABLE_SLOTS)) table_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_fill    (cfg_max_fill),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key_bits     (in_key_bits),
    .in_key_is_string(in_key_is_string),
    .in_string_hash  (in_string_hash),
    .in_store_value  (in_store_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_value_out   (out_value_out),
    .out_new_key     (out_new_key),
    .out_table_full  (out_table_full),
    .errors          (mismatches),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, or for good during a hold-off
  always @(posedge clk) begin
    out_ready <= !hold_rx && (burst || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Hold off the receiver for a long stretch once asked
  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Bail out if the run hangs
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Offer one request beat, idling first at random, and hold it until taken
  task automatic send_req(input logic [1:0] op, input logic [63:0] key, input logic kind,
                          input logic [31:0] h, input logic [63:0] val);
    while (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_key_bits      <= key;
    in_key_is_string <= kind;
    in_string_hash   <= h;
    in_store_value   <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every answer has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_max_fill(input logic [8:0] v);
    cfg_valid    <= 1'b1;
    cfg_max_fill <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A key most likely never seen: a random string or an integral or raw double
  task automatic make_fresh_key(output logic [63:0] key, output logic kind,
                                output logic [31:0] h);
    kind = 1'($urandom_range(0, 1));
    h    = $urandom();
    if (kind || $urandom_range(0, 1) == 0)
      key = {$urandom(), $urandom()};
    else if ($urandom_range(0, 1) == 0)
      key = $realtobits(real'($urandom_range(0, 100000)));
    else
      key = $realtobits(-real'($urandom_range(1, 100000)));
  endtask

  // Random request: mostly pool keys, some fresh ones, rare undefined codes
  task automatic send_mixed();
    int          pick;
    int          idx;
    logic [1:0]  op;
    logic [63:0] key;
    logic        kind;
    logic [31:0] h;
    pick = $urandom_range(0, 99);
    op   = (pick < 40) ? OP_GET : (pick < 78) ? OP_SET : (pick < 98) ? OP_DEL : OP_UNDEF;
    if ($urandom_range(0, 3) != 0) begin
      idx  = $urandom_range(0, POOL - 1);
      key  = pool_key[idx];
      kind = pool_kind[idx];
      h    = kind ? pool_hash[idx] : $urandom();
    end else begin
      make_fresh_key(key, kind, h);
    end
    send_req(op, key, kind, h, {$urandom(), $urandom()});
  endtask

  initial begin
    logic [63:0] key;
    logic        kind;
    logic [31:0] h;

    // Build the key pool: small integers, fractions, strings on crowded homes
    for (int i = 0; i < POOL; i++) begin
      pool_hash[i] = $urandom();
      case (i % 4)
        0: begin
          pool_kind[i] = 1'b0;
          pool_key[i]  = $realtobits((i % 8 == 0) ? -real'(i / 4) : real'(i / 4));
        end
        1: begin
          pool_kind[i] = 1'b0;
          pool_key[i]  = $realtobits(real'(i) + 0.25);
        end
        2: begin
          pool_kind[i]      = 1'b1;
          pool_key[i]       = {$urandom(), $urandom()};
          pool_hash[i][7:0] = 8'($urandom_range(0, 15));
        end
        default: begin
          pool_kind[i]      = 1'b1;
          pool_key[i]       = pool_key[i - 3];
          pool_hash[i][7:0] = 8'($urandom_range(0, 31));
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, hash corner cases, collisions, overwrite, delete
    send_req(OP_GET, 64'h0000_0000_0000_0000, 1'b0, $urandom(), 64'd0);
    send_req(OP_DEL, 64'h0000_0000_0000_0000, 1'b0, $urandom(), 64'd0);
    send_req(OP_SET, 64'h0000_0000_0000_0000, 1'b0, 32'h0000_0000, '1);
    send_req(OP_SET, 64'h8000_0000_0000_0000, 1'b0, '1, 64'd1);
    send_req(OP_GET, 64'h8000_0000_0000_0000, 1'b0, $urandom(), 64'd0);
    send_req(OP_SET, 64'hC3E0_0000_0000_0000, 1'b0, $urandom(), 64'd2);
    send_req(OP_SET, 64'h3FF0_0000_0000_0000, 1'b0, $urandom(), 64'd3);
    send_req(OP_SET, 64'hBFF0_0000_0000_0000, 1'b0, $urandom(), 64'd4);
    send_req(OP_SET, 64'h3FE0_0000_0000_0000, 1'b0, $urandom(), 64'd5);
    send_req(OP_SET, 64'h0000_0000_0000_0001, 1'b0, $urandom(), 64'd6);
    send_req(OP_SET, 64'h7FF0_0000_0000_0000, 1'b0, $urandom(), 64'd7);
    send_req(OP_SET, 64'h7FF8_0000_0000_0001, 1'b0, $urandom(), 64'd8);
    send_req(OP_SET, 64'h43E0_0000_0000_0000, 1'b0, $urandom(), 64'd9);
    send_req(OP_SET, 64'h43B0_0000_0000_0000, 1'b0, $urandom(), 64'd10);
    send_req(OP_SET, '1, 1'b0, $urandom(), 64'd11);
    send_req(OP_SET, 64'h0000_0000_0000_0000, 1'b1, 32'hFFFF_FFFF, 64'd12);
    send_req(OP_SET, 64'h3FF0_0000_0000_0000, 1'b1, 32'h0000_0001, 64'd13);
    send_req(OP_SET, 64'h0000_0000_0000_0000, 1'b0, $urandom(), 64'd14);
    send_req(OP_GET, 64'h0000_0000_0000_0000, 1'b0, $urandom(), 64'd0);
    send_req(OP_DEL, 64'h8000_0000_0000_0000, 1'b0, $urandom(), 64'd0);
    send_req(OP_GET, 64'h8000_0000_0000_0000, 1'b0, $urandom(), 64'd0);
    send_req(OP_GET, 64'hC3E0_0000_0000_0000, 1'b0, $urandom(), 64'd0);
    send_req(OP_DEL, 64'h8000_0000_0000_0000, 1'b0, $urandom(), 64'd0);
    send_req(OP_UNDEF, 64'h0000_0000_0000_0000, 1'b0, '1, '1);
    wait_drain();

    // No room for new slots: tombstone reuse still goes through
    write_max_fill(9'd0);
    send_req(OP_SET, 64'h8000_0000_0000_0000, 1'b0, $urandom(), 64'd15);
    send_req(OP_SET, 64'h4045_0000_0000_0000, 1'b0, $urandom(), 64'd16);
    wait_drain();
    write_max_fill(9'd1);
    send_req(OP_SET, 64'h4045_8000_0000_0000, 1'b0, $urandom(), 64'd17);
    wait_drain();

    // Random traffic with a receiver hold-off, a sender pause and a burst
    write_max_fill(9'($urandom_range(100, 255)));
    for (int n = 0; n < 450; n++) begin
      if (n == 100) start_hold <= 1'b1;
      if (n == 200) wait_drain();
      if (n == 250) burst <= 1'b1;
      if (n == 350) burst <= 1'b0;
      send_mixed();
    end
    wait_drain();
    write_max_fill(9'd1);
    repeat (150) send_mixed();
    wait_drain();
    write_max_fill(9'd256);
    repeat (350) send_mixed();

    // Fill every slot, then probe a table with no empty slot left
    repeat (300) begin
      make_fresh_key(key, kind, h);
      send_req(OP_SET, key, kind, h, {$urandom(), $urandom()});
    end
    repeat (40) begin
      make_fresh_key(key, kind, h);
      send_req(($urandom_range(0, 1) == 0) ? OP_GET : OP_SET, key, kind, h,
               {$urandom(), $urandom()});
    end
    repeat (20) send_mixed();

    wait_drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
